/* rtl/bmw_pkg.sv */
// Shared types and constants for the binary morphology window block.
`timescale 1ns / 1ps

package bmw_pkg;

  localparam int unsigned MAX_WIDTH_C  = 1024;
  localparam int unsigned MAX_HEIGHT_C = 1024;
  localparam int unsigned MAX_HALF_C   = 4;

  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned PIX_W      = 8;

  localparam logic [PIX_W-1:0] PIX_ZERO = 8'd0;
  localparam logic [PIX_W-1:0] PIX_FULL = 8'd255;

  localparam logic [1:0]  MODE_RST     = 2'd2;
  localparam logic [2:0]  HALF_RST     = 3'd2;
  localparam logic [10:0] WIDTH_RST    = 11'd640;
  localparam logic [10:0] HEIGHT_RST   = 11'd480;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE      = 3'd0,
    CFG_HALF_ROWS = 3'd1,
    CFG_HALF_COLS = 3'd2,
    CFG_WIDTH     = 3'd3,
    CFG_HEIGHT    = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OP_ERODE  = 2'd0,
    OP_DILATE = 2'd1,
    OP_OPEN   = 2'd2
  } op_e;

  // Sideband that travels with an item through the stages.
  typedef struct packed {
    logic out_vld;
    logic last;
    logic s2_vld;
    logic s2_clr;
  } tag_t;

endpackage

/* rtl/binary_morphology_window.sv */
// Top level of the binary morphology window: configuration, position control and stages.
`timescale 1ns / 1ps

// The block filters a raster stream of 8-bit pixels with a rectangular window.
// Items enter on the s_axis channel: tdata carries the pixel and tuser marks
// a flush item that carries no pixel. Results leave on the m_axis channel with
// the pixel (0 or 255) in tdata and tlast on the final pixel of a frame.
// The cfg channel writes mode, window radii and frame size; cfg_ready_o is
// always high and writes belong between frames.
// The result for a raster position leaves on the item that lies
// half_rows*width+half_cols items later (twice that for opening), so each
// frame is followed by that many flush items.
// One item is taken per clock. Each window stage adds two register levels;
// the item that releases a result passes the stage registers and then the
// output register before m_axis_tvalid rises, through both stages for opening.
// When the receiver stalls with a result held, the whole pipeline freezes
// and s_axis_tready falls in the same cycle.
// Reset sets the registers to opening with a 5x5 window on 640x480 frames
// and starts a new frame; the line buffers need no clearing.
module binary_morphology_window #(
  parameter int unsigned MAX_WIDTH  = bmw_pkg::MAX_WIDTH_C,
  parameter int unsigned MAX_HEIGHT = bmw_pkg::MAX_HEIGHT_C,
  parameter int unsigned MAX_HALF   = bmw_pkg::MAX_HALF_C
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [bmw_pkg::PIX_W-1:0]      s_axis_tdata,  // pixel_in
  input  logic                           s_axis_tuser,  // command
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [bmw_pkg::PIX_W-1:0]      m_axis_tdata,  // pixel_out
  output logic                           m_axis_tlast,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bmw_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bmw_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import bmw_pkg::*;

  localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
  localparam int unsigned WD_W   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HT_W   = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned HALF_W = $clog2(MAX_HALF + 1);
  localparam int unsigned ROW_W  = $clog2(MAX_HEIGHT + 4 * MAX_HALF + 1);
  localparam int unsigned CNT_W  =
    $clog2(MAX_WIDTH * MAX_HEIGHT + 2 * (MAX_HALF * MAX_WIDTH + MAX_HALF) + 1);

  logic [1:0]  mode_q;
  logic [2:0]  half_rows_q, half_cols_q;
  logic [10:0] width_q, height_q;

  op_e               op;
  logic [WD_W-1:0]   w_c;
  logic [HT_W-1:0]   h_c;
  logic [HALF_W-1:0] hr_c, hc_c;
  logic [CNT_W-1:0]  d1, d;

  logic [CNT_W-1:0] t_cnt_q, t_cnt_d;
  logic [COL_W-1:0] t_col_q, t_col_d;
  logic [ROW_W-1:0] t_row_q, t_row_d;
  logic [COL_W-1:0] e_col_q, e_col_d;
  logic [COL_W-1:0] q_col_q, q_col_d;
  logic [ROW_W-1:0] q_row_q, q_row_d;
  logic [WD_W-1:0]  w_m1;

  logic en, acc, adv, restart, s2_step;
  logic in_hit;
  tag_t tag_in, tag1, tag2, ftag;
  logic hit1, hit2;
  logic [COL_W-1:0] s1_ctr;
  logic [COL_W-1:0] q_col_p1_q, q_col_p2_q;

  logic                m_valid_q;
  logic [PIX_W-1:0]    m_data_q;
  logic                m_last_q;
  logic [PIX_W-1:0]    pix_res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_RST;
      half_rows_q <= HALF_RST;
      half_cols_q <= HALF_RST;
      width_q     <= WIDTH_RST;
      height_q    <= HEIGHT_RST;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_MODE:      mode_q      <= cfg_data_i[1:0];
        CFG_HALF_ROWS: half_rows_q <= cfg_data_i[2:0];
        CFG_HALF_COLS: half_cols_q <= cfg_data_i[2:0];
        CFG_WIDTH:     width_q     <= cfg_data_i;
        CFG_HEIGHT:    height_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (mode_q)
      OP_ERODE:  op = OP_ERODE;
      OP_DILATE: op = OP_DILATE;
      default:   op = OP_OPEN;
    endcase
    if (width_q == '0) begin
      w_c = WD_W'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      w_c = WD_W'(MAX_WIDTH);
    end else begin
      w_c = WD_W'(width_q);
    end
    if (height_q == '0) begin
      h_c = HT_W'(1);
    end else if (32'(height_q) > MAX_HEIGHT) begin
      h_c = HT_W'(MAX_HEIGHT);
    end else begin
      h_c = HT_W'(height_q);
    end
    hr_c = (32'(half_rows_q) > MAX_HALF) ? HALF_W'(MAX_HALF) : HALF_W'(half_rows_q);
    hc_c = (32'(half_cols_q) > MAX_HALF) ? HALF_W'(MAX_HALF) : HALF_W'(half_cols_q);
  end

  assign d1   = CNT_W'(hr_c) * CNT_W'(w_c) + CNT_W'(hc_c);
  assign d    = (op == OP_OPEN) ? {d1[CNT_W-2:0], 1'b0} : d1;
  assign w_m1 = w_c - WD_W'(1);

  assign en            = !m_valid_q || m_axis_tready;
  assign s_axis_tready = en;
  assign acc           = s_axis_tvalid && en;
  assign adv           = acc && !(s_axis_tuser && (t_row_q < ROW_W'(h_c)));
  assign s2_step       = adv && (op == OP_OPEN) && (t_cnt_q >= d1);

  always_comb begin
    logic emit_ph;
    logic q_in;
    logic q_last;
    t_cnt_d = t_cnt_q;
    t_col_d = t_col_q;
    t_row_d = t_row_q;
    e_col_d = e_col_q;
    q_col_d = q_col_q;
    q_row_d = q_row_q;
    restart = 1'b0;
    tag_in  = '0;
    emit_ph = adv && (t_cnt_q >= d);
    q_in    = q_row_q < ROW_W'(h_c);
    q_last  = (q_row_q == ROW_W'(h_c) - ROW_W'(1)) && (q_col_q == w_m1[COL_W-1:0]);
    if (adv) begin
      t_cnt_d = t_cnt_q + CNT_W'(1);
      if (t_col_q == w_m1[COL_W-1:0]) begin
        t_col_d = '0;
        t_row_d = t_row_q + ROW_W'(1);
      end else begin
        t_col_d = t_col_q + COL_W'(1);
      end
    end
    if (s2_step) begin
      e_col_d = (e_col_q == w_m1[COL_W-1:0]) ? '0 : e_col_q + COL_W'(1);
    end
    if (emit_ph) begin
      if (!q_in) begin
        restart = 1'b1;
      end else begin
        tag_in.out_vld = 1'b1;
        tag_in.last    = q_last;
        restart        = q_last;
        if (q_col_q == w_m1[COL_W-1:0]) begin
          q_col_d = '0;
          q_row_d = q_row_q + ROW_W'(1);
        end else begin
          q_col_d = q_col_q + COL_W'(1);
        end
      end
    end
    tag_in.s2_vld = s2_step;
    tag_in.s2_clr = restart && (op == OP_OPEN);
    if (restart) begin
      t_cnt_d = '0;
      t_col_d = '0;
      t_row_d = '0;
      e_col_d = '0;
      q_col_d = '0;
      q_row_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_cnt_q <= '0;
      t_col_q <= '0;
      t_row_q <= '0;
      e_col_q <= '0;
      q_col_q <= '0;
      q_row_q <= '0;
    end else begin
      t_cnt_q <= t_cnt_d;
      t_col_q <= t_col_d;
      t_row_q <= t_row_d;
      e_col_q <= e_col_d;
      q_col_q <= q_col_d;
      q_row_q <= q_row_d;
    end
  end

  assign in_hit = (op == OP_DILATE) ? (s_axis_tdata == PIX_FULL) :
                                      (s_axis_tdata == PIX_ZERO);
  assign s1_ctr = (op == OP_OPEN) ? e_col_q : q_col_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      q_col_p1_q <= q_col_q;
      q_col_p2_q <= q_col_p1_q;
    end
  end

  bmw_stage #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_HALF   (MAX_HALF)
  ) u_stage_first (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .clr_i       (restart),
    .vld_i       (adv),
    .hit_i       (in_hit),
    .ctr_col_i   (s1_ctr),
    .tag_i       (tag_in),
    .width_i     (w_c),
    .height_i    (h_c),
    .half_rows_i (hr_c),
    .half_cols_i (hc_c),
    .hit_o       (hit1),
    .tag_o       (tag1)
  );

  bmw_stage #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_HALF   (MAX_HALF)
  ) u_stage_second (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .clr_i       (tag1.s2_clr),
    .vld_i       (tag1.s2_vld),
    .hit_i       (!hit1),
    .ctr_col_i   (q_col_p2_q),
    .tag_i       (tag1),
    .width_i     (w_c),
    .height_i    (h_c),
    .half_rows_i (hr_c),
    .half_cols_i (hc_c),
    .hit_o       (hit2),
    .tag_o       (tag2)
  );

  always_comb begin
    case (op)
      OP_ERODE: begin
        ftag    = tag1;
        pix_res = hit1 ? PIX_ZERO : PIX_FULL;
      end
      OP_DILATE: begin
        ftag    = tag1;
        pix_res = hit1 ? PIX_FULL : PIX_ZERO;
      end
      default: begin
        ftag    = tag2;
        pix_res = hit2 ? PIX_FULL : PIX_ZERO;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (en) begin
      m_valid_q <= ftag.out_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_data_q <= pix_res;
      m_last_q <= ftag.last;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

endmodule

/* rtl/bmw_stage.sv */
// One window stage: a column line buffer feeding a row of horizontal window cells.
`timescale 1ns / 1ps

module bmw_stage #(
  parameter int unsigned MAX_WIDTH  = bmw_pkg::MAX_WIDTH_C,
  parameter int unsigned MAX_HEIGHT = bmw_pkg::MAX_HEIGHT_C,
  parameter int unsigned MAX_HALF   = bmw_pkg::MAX_HALF_C,
  localparam int unsigned COL_W  = $clog2(MAX_WIDTH),
  localparam int unsigned WD_W   = $clog2(MAX_WIDTH + 1),
  localparam int unsigned HT_W   = $clog2(MAX_HEIGHT + 1),
  localparam int unsigned HALF_W = $clog2(MAX_HALF + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              clr_i,
  input  logic              vld_i,
  input  logic              hit_i,
  input  logic [COL_W-1:0]  ctr_col_i,
  input  bmw_pkg::tag_t     tag_i,
  input  logic [WD_W-1:0]   width_i,
  input  logic [HT_W-1:0]   height_i,
  input  logic [HALF_W-1:0] half_rows_i,
  input  logic [HALF_W-1:0] half_cols_i,
  output logic              hit_o,
  output bmw_pkg::tag_t     tag_o
);
  import bmw_pkg::*;

  localparam int unsigned TAPS  = 2 * MAX_HALF;
  localparam int unsigned CELLS = 2 * MAX_HALF + 1;
  localparam int unsigned ROW_W = $clog2(MAX_HEIGHT + 4 * MAX_HALF + 1);
  localparam int unsigned K_W   = HALF_W + 1;
  localparam int unsigned S_W   = COL_W + HALF_W + 2;

  logic [TAPS-1:0]  mem [MAX_WIDTH];
  logic [TAPS-1:0]  rd_q;
  logic [TAPS-1:0]  wr_data;
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [WD_W-1:0]  w_m1;
  logic             vbit;
  logic [CELLS-1:0] cell_q;
  logic [COL_W-1:0] ctr_q;
  tag_t             tag1_q, tag2_q;
  logic             hhit;
  logic             hit_q;

  assign w_m1    = width_i - WD_W'(1);
  assign wr_data = {rd_q[TAPS-2:0], hit_i};

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (clr_i) begin
      col_d = '0;
      row_d = '0;
    end else if (vld_i) begin
      if (col_q == w_m1[COL_W-1:0]) begin
        col_d = '0;
        row_d = row_q + ROW_W'(1);
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  always_comb begin
    logic [ROW_W-1:0] rr;
    logic             row_ok;
    logic             lim_ok;
    vbit = hit_i && (row_q < ROW_W'(height_i));
    for (int k = 1; k <= TAPS; k++) begin
      rr     = row_q - ROW_W'(k);
      row_ok = (row_q >= ROW_W'(k)) && (rr < ROW_W'(height_i));
      lim_ok = K_W'(k) <= {half_rows_i, 1'b0};
      vbit   = vbit | (rd_q[k-1] & row_ok & lim_ok);
    end
  end

  always_comb begin
    logic signed [S_W-1:0] cpos;
    logic                  ok;
    hhit = 1'b0;
    for (int k = 0; k < CELLS; k++) begin
      cpos = signed'(S_W'(ctr_q)) + signed'(S_W'(half_cols_i)) - signed'(S_W'(k));
      ok   = (K_W'(k) <= {half_cols_i, 1'b0}) && (cpos >= 0) &&
             (cpos < signed'(S_W'(width_i)));
      hhit = hhit | (cell_q[k] & ok);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (vld_i) begin
        mem[col_q] <= wr_data;
      end
      if (vld_i && (col_q == col_d)) begin
        rd_q <= wr_data;
      end else begin
        rd_q <= mem[col_d];
      end
      ctr_q <= ctr_col_i;
      hit_q <= hhit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      cell_q <= '0;
      tag1_q <= '0;
      tag2_q <= '0;
    end else if (en_i) begin
      col_q  <= col_d;
      row_q  <= row_d;
      tag1_q <= tag_i;
      tag2_q <= tag1_q;
      if (vld_i) begin
        cell_q <= {cell_q[CELLS-2:0], vbit};
      end
    end
  end

  assign hit_o = hit_q;
  assign tag_o = tag2_q;

endmodule

/* rtl/bmw_checker.sv */
// Port-level checker for the binary morphology window, bound to the top level.
`timescale 1ns / 1ps

module bmw_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      s_axis_tready,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [bmw_pkg::PIX_W-1:0] m_axis_tdata,
  input logic                      m_axis_tlast
);
  import bmw_pkg::*;

  a_pix_binary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata == PIX_ZERO) || (m_axis_tdata == PIX_FULL))
    else $error("Result pixel is neither 0 nor 255.");

  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("Input stalled without a held result.");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("Stalled result changed.");

endmodule

bind binary_morphology_window bmw_checker u_bmw_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

/* bench/tb_top.sv */
// Self-checking testbench for the binary morphology window with a scoreboard class.
`timescale 1ns / 1ps

module tb_top;
  import bmw_pkg::*;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;
  localparam int RING_ROWS = 3 * MAX_HALF_C + 2;
  localparam int STORE_DEPTH = RING_ROWS * MAX_WIDTH_C;
  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 10;
  localparam int ITEM_TARGET = 1250;

  typedef struct {
    logic [PIX_W-1:0] pixel;
    logic             last;
  } morph_result_t;

  class morph_scoreboard;
    bit [1:0] class_ring[STORE_DEPTH];
    bit eroded_ring[STORE_DEPTH];
    int unsigned in_pos;
    int unsigned out_pos;
    logic [1:0] mode_r = MODE_RST;
    logic [2:0] hrows_r = HALF_RST;
    logic [2:0] hcols_r = HALF_RST;
    logic [10:0] width_r = WIDTH_RST;
    logic [10:0] height_r = HEIGHT_RST;
    morph_result_t pending_q[$];
    int errors;

    function void write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_MODE: mode_r = val[1:0];
        CFG_HALF_ROWS: hrows_r = val[2:0];
        CFG_HALF_COLS: hcols_r = val[2:0];
        CFG_WIDTH: width_r = val;
        CFG_HEIGHT: height_r = val;
        default: ;
      endcase
    endfunction

    function void geometry(output int w, output int h, output int hr, output int hc,
                           output op_e op);
      w = (width_r == 0) ? 1 : (width_r > MAX_WIDTH_C ? MAX_WIDTH_C : width_r);
      h = (height_r == 0) ? 1 : (height_r > MAX_HEIGHT_C ? MAX_HEIGHT_C : height_r);
      hr = (hrows_r > MAX_HALF_C) ? MAX_HALF_C : hrows_r;
      hc = (hcols_r > MAX_HALF_C) ? MAX_HALF_C : hcols_r;
      op = (mode_r >= OP_OPEN) ? OP_OPEN : op_e'(mode_r);
    endfunction

    function int slot(int pos, int w);
      return ((pos / w) % RING_ROWS) * MAX_WIDTH_C + (pos % w);
    endfunction

    function bit window_hit(bit from_eroded, int q, int w, int h, int hr, int hc,
                            bit [1:0] mask);
      int r;
      int c;
      bit [1:0] v;
      r = q / w;
      c = q % w;
      for (int rr = r - hr; rr <= r + hr; rr++) begin
        if (rr < 0 || rr >= h) continue;
        for (int cc = c - hc; cc <= c + hc; cc++) begin
          if (cc < 0 || cc >= w) continue;
          v = from_eroded ? {1'b0, eroded_ring[slot(rr * w + cc, w)]}
                          : class_ring[slot(rr * w + cc, w)];
          if ((v & mask) != 0) return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function void note_item(logic cmd, logic [PIX_W-1:0] pix);
      int w, h, hr, hc, n, d1, lag, t, q;
      op_e op;
      bit full;
      morph_result_t res;
      geometry(w, h, hr, hc, op);
      n = w * h;
      d1 = hr * w + hc;
      lag = (op == OP_OPEN) ? 2 * d1 : d1;
      t = in_pos;
      if (t < n) begin
        if (cmd == CMD_FLUSH) return;
        class_ring[slot(t, w)] = (pix == PIX_ZERO) ? 2'd1 : ((pix == PIX_FULL) ? 2'd2 : 2'd0);
      end
      if (op == OP_OPEN && t >= d1 && t - d1 < n)
        eroded_ring[slot(t - d1, w)] = !window_hit(1'b0, t - d1, w, h, hr, hc, 2'd1);
      in_pos = t + 1;
      if (t < lag) return;
      q = out_pos;
      if (q >= n) begin
        in_pos = 0;
        out_pos = 0;
        return;
      end
      case (op)
        OP_ERODE: full = !window_hit(1'b0, q, w, h, hr, hc, 2'd1);
        OP_DILATE: full = window_hit(1'b0, q, w, h, hr, hc, 2'd2);
        default: full = window_hit(1'b1, q, w, h, hr, hc, 2'd1);
      endcase
      res.pixel = full ? PIX_FULL : PIX_ZERO;
      res.last = (q == n - 1);
      pending_q.push_back(res);
      out_pos = q + 1;
      if (q == n - 1) begin
        in_pos = 0;
        out_pos = 0;
      end
    endfunction

    function void check_result(logic [PIX_W-1:0] pix, logic last);
      morph_result_t exp_r;
      if (pending_q.size() == 0) begin
        $error("unexpected result: pixel_out %0d frame_last %0b", pix, last);
        errors++;
        return;
      end
      exp_r = pending_q.pop_front();
      if (pix !== exp_r.pixel) begin
        $error("pixel_out mismatch: expected %0d, actual %0d", exp_r.pixel, pix);
        errors++;
      end
      if (last !== exp_r.last) begin
        $error("frame_last mismatch: expected %0b, actual %0b", exp_r.last, last);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [PIX_W-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [PIX_W-1:0] m_axis_tdata;
  logic m_axis_tlast;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  morph_scoreboard sb = new();
  int burst_left = 0;
  int items_sent = 0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int stall_kind = 0;
  int stall_left = 0;
  int idle_cycles = 0;

  always #2 clk_i = ~clk_i;

  binary_morphology_window DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i)
  );

  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_kind = $urandom_range(0, 2);
        stall_left = $urandom_range(16, 128);
      end else begin
        stall_left--;
      end
      case (stall_kind)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= 1'($urandom_range(0, 1));
        default: m_axis_tready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata, m_axis_tlast);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("** binary_morphology_window: FAILED **");
        $finish;
      end
    end
  end

  task automatic write_config(logic [10:0] mode, logic [10:0] hr, logic [10:0] hc,
                              logic [10:0] w, logic [10:0] h);
    logic [10:0] vals[5];
    vals = '{mode, hr, hc, w, h};
    for (int i = 0; i < 5; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= cfg_idx_e'(i);
      cfg_data_i <= vals[i];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      sb.write_reg(cfg_idx_e'(i), vals[i]);
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_item(logic cmd, logic [PIX_W-1:0] pix);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 60);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= pix;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_item(cmd, pix);
    items_sent++;
  endtask

  function automatic logic [PIX_W-1:0] pick_pixel();
    if ($urandom_range(0, 4) == 0) return PIX_W'($urandom_range(0, 255));
    return $urandom_range(0, 1) ? PIX_FULL : PIX_ZERO;
  endfunction

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.pending_q.size() > 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // A frame of pixels with occasional ignored flushes, then the tail that pushes
  // the window past the frame end, mixing flushes and surplus pixels.
  task automatic run_frame();
    int w, h, hr, hc, lag;
    op_e op;
    sb.geometry(w, h, hr, hc, op);
    lag = (op == OP_OPEN) ? 2 * (hr * w + hc) : hr * w + hc;
    for (int i = 0; i < w * h; i++) begin
      if ($urandom_range(0, 19) == 0) send_item(CMD_FLUSH, PIX_W'($urandom_range(0, 255)));
      send_item(CMD_PIXEL, pick_pixel());
    end
    for (int i = 0; i < lag; i++)
      send_item($urandom_range(0, 3) == 0 ? CMD_PIXEL : CMD_FLUSH,
                PIX_W'($urandom_range(0, 255)));
    drain();
  endtask

  initial begin
    logic [PIX_W-1:0] first_frame[9];
    first_frame = '{8'd0, 8'd255, 8'd128, 8'd1, 8'd254, 8'd255, 8'd255, 8'd0, 8'd255};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_config(OP_ERODE, 1, 1, 3, 3);
    send_item(CMD_FLUSH, 8'd0);
    foreach (first_frame[i]) send_item(CMD_PIXEL, first_frame[i]);
    send_item(CMD_PIXEL, 8'd255);
    repeat (3) send_item(CMD_FLUSH, 8'd255);
    drain();

    write_config(3, 0, 1, 4, 2);
    run_frame();
    write_config(OP_DILATE, 5, 0, 0, 6);
    run_frame();

    hold_req = 1'b1;
    write_config(OP_ERODE, 0, 7, 2047, 0);
    run_frame();
    write_config(OP_DILATE, 7, 0, 0, 12);
    run_frame();

    while (items_sent < ITEM_TARGET) begin
      write_config(11'($urandom_range(0, 3)),
                   11'($urandom_range(0, 9) == 0 ? $urandom_range(5, 7)
                                                 : $urandom_range(0, 4)),
                   11'($urandom_range(0, 9) == 0 ? $urandom_range(5, 7)
                                                 : $urandom_range(0, 4)),
                   11'($urandom_range(0, 10)), 11'($urandom_range(0, 10)));
      run_frame();
    end

    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("** binary_morphology_window: PASSED **");
    end else begin
      $display("** binary_morphology_window: FAILED **");
    end
    $finish;
  end

endmodule
